// ===== rtl/core/mwik_pkg.sv =====
package mwik_pkg;

   // Default build options
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF    = 16;

   // Field widths
   localparam int SPEED_W    = 16;
   localparam int ANG_W      = 16;
   localparam int GEOM_W     = 12;
   localparam int INVR_W     = 16;
   localparam int WHEEL_W    = 20;
   localparam int TRIG_W     = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int NUM_WHEELS = 4;

   // CORDIC datapath, Q30
   localparam int XY_W = 32;
   localparam logic signed [XY_W-1:0] X_INIT     = 32'sd652032875;
   localparam logic signed [XY_W-1:0] ROUND_Q15  = 32'sd16384;
   localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd32767;

   // Register reset values
   localparam logic [GEOM_W-1:0] GEOM_RESET = 12'd300;
   localparam logic [INVR_W-1:0] INVR_RESET = 16'd1311;

   // Register map, by word index
   typedef enum logic {
      REG_GEOMETRY   = 1'b0,
      REG_INV_RADIUS = 1'b1
   } csr_index_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   typedef logic [31:0] atan_tab_type [24];
   localparam atan_tab_type ATAN_TURN32 = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Arctangent step rounded to the angle resolution
   function automatic logic [32:0] atan_step(input int idx, input int abits);
      logic [32:0] v;
      v = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - abits));
      return v >> (32 - abits);
   endfunction

   // Command terms that ride alongside the rotation
   typedef struct packed {
      logic signed [SPEED_W-1:0] lin_speed;
      logic signed [SPEED_W-1:0] yaw_rate;
   } side_type;

   // Rotation result into the wheel path
   typedef struct packed {
      logic                     valid;
      logic signed [TRIG_W-1:0] cos_q15;
      logic signed [TRIG_W-1:0] sin_q15;
      side_type                 side;
   } trig_type;

   // Finished result beat
   typedef struct packed {
      logic                                 valid;
      logic [NUM_WHEELS-1:0][WHEEL_W-1:0]   wheel;
      logic                                 saturated;
   } rsp_type;

endpackage

// ===== rtl/core/mwik_csr.sv =====
module mwik_csr import mwik_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [GEOM_W-1:0]     geometry_sum_mm,
   output logic [INVR_W-1:0]     inv_radius_q16
);

   logic          wr_beat;
   csr_index_type idx;
   logic [GEOM_W-1:0] geometry_ff;
   logic [INVR_W-1:0] inv_radius_ff;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite;
   assign idx     = csr_index_type'(paddr[2]);

   // Register writes, low bits kept
   always_ff @(posedge clock) begin
      if (reset) begin
         geometry_ff   <= GEOM_RESET;
         inv_radius_ff <= INVR_RESET;
      end else if (wr_beat) begin
         case (idx)
            REG_GEOMETRY:   geometry_ff   <= pwdata[GEOM_W-1:0];
            REG_INV_RADIUS: inv_radius_ff <= pwdata[INVR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_GEOMETRY:   prdata = CSR_DATA_W'(geometry_ff);
         REG_INV_RADIUS: prdata = CSR_DATA_W'(inv_radius_ff);
         default:        prdata = '0;
      endcase
   end

   assign geometry_sum_mm = geometry_ff;
   assign inv_radius_q16  = inv_radius_ff;

endmodule

// ===== rtl/core/mwik_cordic.sv =====
module mwik_cordic import mwik_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [ANG_W-1:0] travel_dir,
   input  logic [ANG_W-1:0] heading,
   input  side_type         side,
   output trig_type         trig
);

   localparam int Z_W = ANGLE_BITS + 1;
   localparam int R_W = XY_W - 15;

   // Round Q30 to Q15 and clamp to the symmetric range
   function automatic logic signed [TRIG_W-1:0] round_q15(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] t;
      logic signed [R_W-1:0]  r;
      logic signed [TRIG_W-1:0] q;
      t = v + ROUND_Q15;
      r = signed'(t[XY_W-1:15]);
      if (r > R_W'(TRIG_MAX))
         q = TRIG_MAX;
      else if (r < -R_W'(TRIG_MAX))
         q = -TRIG_MAX;
      else
         q = r[TRIG_W-1:0];
      return q;
   endfunction

   logic [ANG_W-1:0]      diff;
   logic [ANGLE_BITS-1:0] ang;
   logic                  flip_in;
   logic signed [Z_W-1:0] z0_in;

   logic                   valid_ff [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] x_ff     [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] y_ff     [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  z_ff     [CORDIC_STAGES+1];
   logic                   flip_ff  [CORDIC_STAGES+1];
   side_type               side_ff  [CORDIC_STAGES+1];

   logic                     out_valid_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   side_type                 out_side_ff;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_in;

   // Angle difference scaled to the working resolution
   assign diff = travel_dir - heading;

   generate
      if (ANGLE_BITS <= ANG_W) begin : g_narrow
         assign ang = diff[ANG_W-1 -: ANGLE_BITS];
      end else begin : g_wide
         assign ang = {diff, {(ANGLE_BITS-ANG_W){1'b0}}};
      end
   endgenerate

   // Fold the half turn around pi onto the right half plane
   assign flip_in = ang[ANGLE_BITS-1] ^ ang[ANGLE_BITS-2];
   assign z0_in   = signed'({ang[ANGLE_BITS-2], ang[ANGLE_BITS-2], ang[ANGLE_BITS-2],
                             ang[ANGLE_BITS-3:0]});

   // Entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= X_INIT;
      y_ff[0]    <= '0;
      z_ff[0]    <= z0_in;
      flip_ff[0] <= flip_in;
      side_ff[0] <= side;
   end

   // One micro-rotation per stage
   generate
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
         localparam logic [32:0] T_FULL = atan_step(i, ANGLE_BITS);
         localparam logic signed [Z_W-1:0] T_STEP = signed'(T_FULL[Z_W-1:0]);

         logic signed [XY_W-1:0] dx;
         logic signed [XY_W-1:0] dy;
         logic signed [XY_W-1:0] x_in;
         logic signed [XY_W-1:0] y_in;
         logic signed [Z_W-1:0]  z_in;

         always_comb begin
            dx = y_ff[i] >>> i;
            dy = x_ff[i] >>> i;
            if (!z_ff[i][Z_W-1]) begin
               x_in = x_ff[i] - dx;
               y_in = y_ff[i] + dy;
               z_in = z_ff[i] - T_STEP;
            end else begin
               x_in = x_ff[i] + dx;
               y_in = y_ff[i] - dy;
               z_in = z_ff[i] + T_STEP;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i+1] <= 1'b0;
            end else begin
               valid_ff[i+1] <= valid_ff[i];
            end
         end

         always_ff @(posedge clock) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   endgenerate

   // Round, clamp, undo the fold
   always_comb begin
      cos_in = round_q15(x_ff[CORDIC_STAGES]);
      sin_in = round_q15(y_ff[CORDIC_STAGES]);
      if (flip_ff[CORDIC_STAGES]) begin
         cos_in = -cos_in;
         sin_in = -sin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      out_side_ff <= side_ff[CORDIC_STAGES];
   end

   assign trig.valid   = out_valid_ff;
   assign trig.cos_q15 = cos_ff;
   assign trig.sin_q15 = sin_ff;
   assign trig.side    = out_side_ff;

endmodule

// ===== rtl/core/mwik_wheel.sv =====
module mwik_wheel import mwik_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  trig_type          trig,
   input  logic [GEOM_W-1:0] geometry_sum_mm,
   input  logic [INVR_W-1:0] inv_radius_q16,
   output rsp_type           rsp
);

   localparam int DIR_W  = TRIG_W + 1;             // c +/- s
   localparam int K_W    = SPEED_W + GEOM_W + 1;   // yaw * geometry
   localparam int TERM_W = SPEED_W + DIR_W;        // v * (c +/- s)
   localparam int KK_W   = K_W + 7;                // k scaled to Q15
   localparam int SUM_W  = KK_W + 1;
   localparam int LO_W   = 18;
   localparam int HI_W   = SUM_W - LO_W;
   localparam int PLO_W  = LO_W + INVR_W;
   localparam int PHI_W  = HI_W + INVR_W + 1;
   localparam int PROD_W = SUM_W + INVR_W + 1;
   localparam int Q_W    = PROD_W - 23;
   localparam logic signed [PROD_W-1:0] ROUND_Q8 = PROD_W'(64'sd4194304);
   localparam int NSTG   = 6;

   logic vld_ff [NSTG];

   // Stage 1: trig sums, yaw term
   logic signed [DIR_W-1:0]   dm_dir_ff, dp_dir_ff;
   logic signed [K_W-1:0]     k1_ff;
   logic signed [SPEED_W-1:0] v1_ff;
   // Stage 2: speed terms
   logic signed [TERM_W-1:0]  dm_ff, dp_ff;
   logic signed [K_W-1:0]     k2_ff;
   // Stage 3 to 6 per wheel
   logic signed [SUM_W-1:0]   sum_ff  [NUM_WHEELS];
   logic [PLO_W-1:0]          plo_ff  [NUM_WHEELS];
   logic signed [PHI_W-1:0]   phi_ff  [NUM_WHEELS];
   logic signed [PROD_W-1:0]  prod_ff [NUM_WHEELS];
   logic [WHEEL_W-1:0]        wheel_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]     sat_vec;
   logic                      sat_ff;

   logic signed [KK_W-1:0]    kk;

   // Valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NSTG; n++) vld_ff[n] <= 1'b0;
      end else begin
         vld_ff[0] <= trig.valid;
         for (int n = 1; n < NSTG; n++) vld_ff[n] <= vld_ff[n-1];
      end
   end

   // Stage 1
   always_ff @(posedge clock) begin
      dm_dir_ff <= DIR_W'(trig.cos_q15) - DIR_W'(trig.sin_q15);
      dp_dir_ff <= DIR_W'(trig.cos_q15) + DIR_W'(trig.sin_q15);
      k1_ff     <= K_W'(trig.side.yaw_rate) * K_W'(signed'({1'b0, geometry_sum_mm}));
      v1_ff     <= trig.side.lin_speed;
   end

   // Stage 2
   always_ff @(posedge clock) begin
      dm_ff <= TERM_W'(v1_ff) * TERM_W'(dm_dir_ff);
      dp_ff <= TERM_W'(v1_ff) * TERM_W'(dp_dir_ff);
      k2_ff <= k1_ff;
   end

   assign kk = signed'({k2_ff, 7'b0});

   generate
      for (genvar j = 0; j < NUM_WHEELS; j++) begin : g_wheel
         // Front left and rear right use c - s; front right and rear left c + s
         localparam bit USE_DP = (j == 1) || (j == 3);
         localparam bit ADD_K  = (j == 1) || (j == 2);

         logic signed [SUM_W-1:0]  sum_in;
         logic signed [PROD_W-1:0] prod_in;
         logic signed [Q_W-1:0]    q;
         logic [WHEEL_W-1:0]       wheel_in;
         logic                     sat_in;

         // Stage 3: add or subtract the yaw term
         always_comb begin
            if (USE_DP) begin
               sum_in = ADD_K ? SUM_W'(dp_ff) + SUM_W'(kk) : SUM_W'(dp_ff) - SUM_W'(kk);
            end else begin
               sum_in = ADD_K ? SUM_W'(dm_ff) + SUM_W'(kk) : SUM_W'(dm_ff) - SUM_W'(kk);
            end
         end

         always_ff @(posedge clock) begin
            sum_ff[j] <= sum_in;
         end

         // Stage 4: split product, low part unsigned, high part signed
         always_ff @(posedge clock) begin
            plo_ff[j] <= PLO_W'(sum_ff[j][LO_W-1:0]) * PLO_W'(inv_radius_q16);
            phi_ff[j] <= PHI_W'(signed'(sum_ff[j][SUM_W-1:LO_W]))
                         * PHI_W'(signed'({1'b0, inv_radius_q16}));
         end

         // Stage 5: recombine and add the rounding half
         assign prod_in = (PROD_W'(phi_ff[j]) <<< LO_W)
                          + signed'(PROD_W'(plo_ff[j])) + ROUND_Q8;

         always_ff @(posedge clock) begin
            prod_ff[j] <= prod_in;
         end

         // Stage 6: drop to Q8 and saturate
         always_comb begin
            q      = signed'(prod_ff[j][PROD_W-1:23]);
            sat_in = (q[Q_W-1:WHEEL_W-1] != {(Q_W-WHEEL_W+1){1'b0}})
                  && (q[Q_W-1:WHEEL_W-1] != {(Q_W-WHEEL_W+1){1'b1}});
            if (sat_in)
               wheel_in = q[Q_W-1] ? {1'b1, {(WHEEL_W-1){1'b0}}} : {1'b0, {(WHEEL_W-1){1'b1}}};
            else
               wheel_in = q[WHEEL_W-1:0];
         end

         assign sat_vec[j] = sat_in;

         always_ff @(posedge clock) begin
            wheel_ff[j] <= wheel_in;
         end

         assign rsp.wheel[j] = wheel_ff[j];
      end
   endgenerate

   always_ff @(posedge clock) begin
      sat_ff <= |sat_vec;
   end

   assign rsp.valid     = vld_ff[NSTG-1];
   assign rsp.saturated = sat_ff;

endmodule

// ===== rtl/core/mecanum_wheel_inverse_kinematics.sv =====
// Channel    | Ports                                   | Beat taken when
// -----------+-----------------------------------------+-------------------------------
// command    | start, busy, req_*                      | start high and busy low
// result     | rsp_valid, rsp_*                        | rsp_valid high (one cycle each)
// registers  | psel, penable, pwrite, paddr, pwdata,   | psel, penable, pwrite, pready
//            | prdata, pready                          |
//
// One command is taken every cycle; busy never rises.
// A command passes through one entry stage, one stage per CORDIC
// micro-rotation, one rounding stage, then six stages in the wheel path.
// Reset clears every valid bit and restores both registers to their defaults.
// The receiver cannot stall, so results leave on a fixed schedule.
module mecanum_wheel_inverse_kinematics import mwik_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // command
   input  logic                      start,
   output logic                      busy,
   input  logic signed [SPEED_W-1:0] req_lin_speed,
   input  logic signed [SPEED_W-1:0] req_yaw_rate,
   input  logic [ANG_W-1:0]          req_travel_dir,
   input  logic [ANG_W-1:0]          req_heading,
   // result
   output logic                      rsp_valid,
   output logic signed [WHEEL_W-1:0] rsp_wheel_front_left,
   output logic signed [WHEEL_W-1:0] rsp_wheel_front_right,
   output logic signed [WHEEL_W-1:0] rsp_wheel_rear_right,
   output logic signed [WHEEL_W-1:0] rsp_wheel_rear_left,
   output logic                      rsp_saturated,
   // registers
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   logic              cmd_beat;
   side_type          side;
   trig_type          trig;
   rsp_type           rsp;
   logic [GEOM_W-1:0] geometry_sum_mm;
   logic [INVR_W-1:0] inv_radius_q16;

   assign busy     = 1'b0;
   assign cmd_beat = start & ~busy;

   assign side.lin_speed = req_lin_speed;
   assign side.yaw_rate  = req_yaw_rate;

   mwik_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .geometry_sum_mm (geometry_sum_mm),
      .inv_radius_q16  (inv_radius_q16)
   );

   // cos/sin of direction relative to heading
   mwik_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cmd_beat),
      .travel_dir (req_travel_dir),
      .heading    (req_heading),
      .side       (side),
      .trig       (trig)
   );

   // Wheel mixing, scaling and saturation
   mwik_wheel u_wheel (
      .clock           (clock),
      .reset           (reset),
      .trig            (trig),
      .geometry_sum_mm (geometry_sum_mm),
      .inv_radius_q16  (inv_radius_q16),
      .rsp             (rsp)
   );

   assign rsp_valid             = rsp.valid;
   assign rsp_wheel_front_left  = signed'(rsp.wheel[0]);
   assign rsp_wheel_front_right = signed'(rsp.wheel[1]);
   assign rsp_wheel_rear_right  = signed'(rsp.wheel[2]);
   assign rsp_wheel_rear_left   = signed'(rsp.wheel[3]);
   assign rsp_saturated         = rsp.saturated;

endmodule
